FILE: src/amb_pkg.sv
// ---------------------------------------------------------------------------
// amb_pkg: shared types and constants for the affine matrix builder
// Fixed-point formats, CORDIC constants and the arctangent table.
// ---------------------------------------------------------------------------
package amb_pkg;

  typedef logic signed [31:0] q16_t;     // Q16.16 value
  typedef logic signed [15:0] ang_t;     // Q3.12 radians
  typedef logic signed [33:0] xy_t;      // CORDIC x / y, Q2.30 plus headroom
  typedef logic signed [32:0] zt_t;      // CORDIC residual angle, binary turns
  typedef logic signed [17:0] unit_t;    // sine / cosine, Q1.16 within +-1.0
  typedef logic signed [18:0] rot_t;     // rotation element, Q2.16

  typedef struct packed {
    xy_t x;
    xy_t y;
    zt_t z;
  } cordic_t;

  typedef struct packed {
    unit_t sx;
    unit_t cx;
    unit_t sy;
    unit_t cy;
    unit_t sz;
    unit_t cz;
  } trig_set_t;

  typedef struct packed {
    q16_t [2:0]       sc;
    q16_t [2:0]       mv;
    logic [2:0][1:0]  quad;
  } side_t;

  localparam int unsigned   ATAN_ENTRIES = 24;
  localparam logic [31:0]   GAIN_Q30     = 32'd652032874;
  localparam logic [30:0]   TURN_SCALE   = 31'd1367130551;
  localparam q16_t          ONE_Q16      = 32'sd65536;
  localparam logic [1:0]    ROW_LAST     = 2'd3;

  function automatic zt_t atan_turn(input int unsigned idx);
    zt_t v;
    unique case (idx)
      0:  v = 33'sd536870912;
      1:  v = 33'sd316933406;
      2:  v = 33'sd167458907;
      3:  v = 33'sd85004756;
      4:  v = 33'sd42667331;
      5:  v = 33'sd21354465;
      6:  v = 33'sd10679838;
      7:  v = 33'sd5340245;
      8:  v = 33'sd2670163;
      9:  v = 33'sd1335087;
      10: v = 33'sd667544;
      11: v = 33'sd333772;
      12: v = 33'sd166886;
      13: v = 33'sd83443;
      14: v = 33'sd41722;
      15: v = 33'sd20861;
      16: v = 33'sd10430;
      17: v = 33'sd5215;
      18: v = 33'sd2608;
      19: v = 33'sd1304;
      20: v = 33'sd652;
      21: v = 33'sd326;
      22: v = 33'sd163;
      23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/amb_if.sv
// ---------------------------------------------------------------------------
// amb_in_if / amb_out_if: request channels of the affine matrix builder
// Valid/ready handshake with the request payload.
// ---------------------------------------------------------------------------
interface amb_in_if;
  import amb_pkg::*;
  logic valid;
  logic ready;
  q16_t scale_x;
  q16_t scale_y;
  q16_t scale_z;
  ang_t angle_x;
  ang_t angle_y;
  ang_t angle_z;
  q16_t move_x;
  q16_t move_y;
  q16_t move_z;
  modport source (output valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                  move_x, move_y, move_z, input ready);
  modport sink   (input valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                  move_x, move_y, move_z, output ready);
endinterface

interface amb_out_if;
  import amb_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] row_index;
  q16_t       col0;
  q16_t       col1;
  q16_t       col2;
  q16_t       col3;
  logic       last_row;
  modport source (output valid, row_index, col0, col1, col2, col3, last_row, input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, last_row, output ready);
endinterface

FILE: src/amb_cordic_cell.sv
// ---------------------------------------------------------------------------
// amb_cordic_cell: one CORDIC rotation step for three angle lanes
// Holds x, y, z of each lane and hands them to the next cell.
// ---------------------------------------------------------------------------
module amb_cordic_cell
  import amb_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             adv,
  input  cordic_t [2:0]    lane_in,
  output cordic_t [2:0]    lane_out
);

  localparam zt_t ATAN = atan_turn(STEP);

  cordic_t [2:0] lane_r;
  cordic_t [2:0] lane_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xy_t xs;
      xy_t ys;
      xs = lane_in[k].x >>> STEP;
      ys = lane_in[k].y >>> STEP;
      if (lane_in[k].z >= 0) begin
        lane_nxt[k].x = lane_in[k].x - ys;
        lane_nxt[k].y = lane_in[k].y + xs;
        lane_nxt[k].z = lane_in[k].z - ATAN;
      end else begin
        lane_nxt[k].x = lane_in[k].x + ys;
        lane_nxt[k].y = lane_in[k].y - xs;
        lane_nxt[k].z = lane_in[k].z + ATAN;
      end
    end
  end

  // advance with the pipeline, hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

FILE: src/amb_matrix.sv
// ---------------------------------------------------------------------------
// amb_matrix: rotation composition and scaling
// Six register stages: Ry*Rz, Rx*(Ry*Rz), then per-row scale.
// ---------------------------------------------------------------------------
module amb_matrix
  import amb_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  trig_set_t        trig,
  input  q16_t [2:0]       sc,      // scales, aligned with the fourth stage
  output q16_t [8:0]       elem
);

  typedef logic signed [35:0] p36_t;
  typedef logic signed [50:0] p51_t;

  // stage 1: products of Ry*Rz
  p36_t      cycz_r, cysz_r, sycz_r, sysz_r;
  trig_set_t t1_r;
  // stage 2: Ry*Rz rounded
  unit_t [2:0][2:0] e2_r;
  unit_t     cx2_r, sx2_r;
  // stage 3: products for rows 1 and 2
  p36_t [2:0] a1_r, b1_r, a2_r, b2_r;
  unit_t [2:0] row0_r;
  // stage 4: rotation
  rot_t [2:0][2:0] rot_r;
  // stage 5: scaled products
  p51_t [8:0] sp_r;
  // stage 6: rounded and saturated
  q16_t [8:0] elem_r;

  function automatic unit_t rnd36(input p36_t p);
    p36_t v;
    v = (p + 36'sd32768) >>> 16;
    return v[17:0];
  endfunction

  function automatic rot_t rnd37(input logic signed [36:0] p);
    logic signed [36:0] v;
    v = (p + 37'sd32768) >>> 16;
    return v[18:0];
  endfunction

  function automatic q16_t rnd_sat(input p51_t p);
    p51_t v;
    v = (p + 51'sd32768) >>> 16;
    if (v > 51'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -51'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      cycz_r <= 36'(trig.cy * trig.cz);
      cysz_r <= 36'(trig.cy * trig.sz);
      sycz_r <= 36'(trig.sy * trig.cz);
      sysz_r <= 36'(trig.sy * trig.sz);
      t1_r   <= trig;

      e2_r[0][0] <= rnd36(cycz_r);
      e2_r[0][1] <= rnd36(cysz_r);
      e2_r[0][2] <= -t1_r.sy;
      e2_r[1][0] <= -t1_r.sz;
      e2_r[1][1] <= t1_r.cz;
      e2_r[1][2] <= '0;
      e2_r[2][0] <= rnd36(sycz_r);
      e2_r[2][1] <= rnd36(sysz_r);
      e2_r[2][2] <= t1_r.cy;
      cx2_r      <= t1_r.cx;
      sx2_r      <= t1_r.sx;

      for (int j = 0; j < 3; j++) begin
        a1_r[j]   <= 36'(cx2_r * e2_r[1][j]);
        b1_r[j]   <= 36'(sx2_r * e2_r[2][j]);
        a2_r[j]   <= 36'(sx2_r * e2_r[1][j]);
        b2_r[j]   <= 36'(cx2_r * e2_r[2][j]);
        row0_r[j] <= e2_r[0][j];
      end

      for (int j = 0; j < 3; j++) begin
        rot_r[0][j] <= 19'(row0_r[j]);
        rot_r[1][j] <= rnd37(37'(a1_r[j]) + 37'(b1_r[j]));
        rot_r[2][j] <= rnd37(37'(b2_r[j]) - 37'(a2_r[j]));
      end

      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          sp_r[r*3+j] <= 51'($signed(sc[r]) * rot_r[r][j]);
        end
      end

      for (int k = 0; k < 9; k++) begin
        elem_r[k] <= rnd_sat(sp_r[k]);
      end
    end
  end

  assign elem = elem_r;

endmodule

FILE: src/affine_matrix_builder.sv
// ---------------------------------------------------------------------------
// affine_matrix_builder: scale / rotate / translate 4x4 affine matrix
// Takes scale, Euler angles and translation; sends the matrix row by row.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  in_req    in   valid/ready            scale_x..z, angle_x..z, move_x..z
//  out_res   out  valid/ready            row_index, col0..col3, last_row
//
// The row sender takes a new matrix only as the last row of the one before goes out,
// so the four output rows of each request set the sustained request rate.
// The pipeline accepts a request in every cycle while its tail is free.
// Reset clears the stage valid bits and the row sender; no clearing pass.
// A stall on out_res freezes every stage once the tail stage holds a finished matrix; the row sender keeps its matrix.
//
module affine_matrix_builder
  import amb_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  amb_in_if.sink  in_req,
  amb_out_if.source out_res
);

  // stage map: 0 angle product, 1 quadrant split, 2..N+1 CORDIC cells,
  // N+2 sine/cosine, N+3..N+8 matrix stages
  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned STAGES = N + 9;
  localparam int unsigned LAST   = STAGES - 1;
  localparam int unsigned SC_TAP = N + 6;

  logic              adv;
  logic              in_fire;
  logic              load;
  logic              load_ok;
  logic [STAGES-1:0] vld_r;
  side_t             side_r [STAGES];

  // stage 0: angle times 2^32/pi
  logic signed [47:0] prod_r [3];
  ang_t               ang [3];

  assign ang[0] = in_req.angle_x;
  assign ang[1] = in_req.angle_y;
  assign ang[2] = in_req.angle_z;

  assign in_fire      = in_req.valid && in_req.ready;
  assign in_req.ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= 48'(ang[k] * $signed({1'b0, TURN_SCALE}));
      end
      side_r[0].sc   <= {in_req.scale_z, in_req.scale_y, in_req.scale_x};
      side_r[0].mv   <= {in_req.move_z, in_req.move_y, in_req.move_x};
      side_r[0].quad <= '0;
    end
  end

  // stage 1: binary angle, quadrant and residual
  cordic_t [2:0]     lane_b;
  logic [2:0][1:0]   quad_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [48:0] sum;
      logic [31:0]        b;
      logic [1:0]         q;
      logic [1:0]         top;
      sum = 49'(prod_r[k]) + 49'sd4096;
      b   = sum[44:13];
      q   = b[31:30] + {1'b0, b[29]};
      top = b[31:30] - q;
      quad_b[k]   = q;
      lane_b[k].x = 34'(GAIN_Q30);
      lane_b[k].y = '0;
      lane_b[k].z = {top[1], top, b[29:0]};
    end
  end

  cordic_t [2:0] chain [N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0]          <= lane_b;
      side_r[1].sc      <= side_r[0].sc;
      side_r[1].mv      <= side_r[0].mv;
      side_r[1].quad    <= quad_b;
    end
  end

  // CORDIC cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    amb_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .adv      (adv),
      .lane_in  (chain[i]),
      .lane_out (chain[i+1])
    );
  end

  for (genvar s = 2; s < STAGES; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // stage N+2: quadrant map and Q1.16 conversion
  function automatic unit_t to_unit(input logic signed [34:0] v30);
    logic signed [34:0] v;
    v = (v30 + 35'sd8192) >>> 14;
    if (v > 35'sd65536) return 18'sd65536;
    if (v < -35'sd65536) return -18'sd65536;
    return v[17:0];
  endfunction

  unit_t     sn [3];
  unit_t     cs [3];
  trig_set_t trig_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [34:0] x;
      logic signed [34:0] y;
      logic signed [34:0] c;
      logic signed [34:0] s;
      x = 35'(chain[N][k].x);
      y = 35'(chain[N][k].y);
      unique case (side_r[N+1].quad[k])
        2'd0:    begin c = x;  s = y;  end
        2'd1:    begin c = -y; s = x;  end
        2'd2:    begin c = -x; s = -y; end
        default: begin c = y;  s = -x; end
      endcase
      sn[k] = to_unit(s);
      cs[k] = to_unit(c);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_r <= '{sx: sn[0], cx: cs[0], sy: sn[1], cy: cs[1], sz: sn[2], cz: cs[2]};
    end
  end

  q16_t [8:0] elem;

  amb_matrix u_matrix (
    .clk  (clk),
    .adv  (adv),
    .trig (trig_r),
    .sc   (side_r[SC_TAP].sc),
    .elem (elem)
  );

  // stage valid bits: shift on advance, drop nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_fire};
    end
  end

  // row sender: holds one finished matrix, sends four rows
  logic       busy_r;
  logic [1:0] row_r;
  q16_t [8:0] mat_r;
  q16_t [2:0] mv_r;
  logic       out_fire;

  assign out_fire = out_res.valid && out_res.ready;
  assign load_ok  = !busy_r || (out_res.ready && row_r == ROW_LAST);
  assign load     = vld_r[LAST] && load_ok;
  assign adv      = !vld_r[LAST] || load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      row_r  <= '0;
    end else if (out_fire) begin
      if (row_r == ROW_LAST) begin
        busy_r <= 1'b0;
      end
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mat_r <= elem;
      mv_r  <= side_r[LAST].mv;
    end
  end

  always_comb begin
    unique case (row_r)
      2'd0: begin
        out_res.col0 = mat_r[0]; out_res.col1 = mat_r[1];
        out_res.col2 = mat_r[2]; out_res.col3 = '0;
      end
      2'd1: begin
        out_res.col0 = mat_r[3]; out_res.col1 = mat_r[4];
        out_res.col2 = mat_r[5]; out_res.col3 = '0;
      end
      2'd2: begin
        out_res.col0 = mat_r[6]; out_res.col1 = mat_r[7];
        out_res.col2 = mat_r[8]; out_res.col3 = '0;
      end
      default: begin
        out_res.col0 = mv_r[0]; out_res.col1 = mv_r[1];
        out_res.col2 = mv_r[2]; out_res.col3 = ONE_Q16;
      end
    endcase
  end

  assign out_res.valid     = busy_r;
  assign out_res.row_index = row_r;
  assign out_res.last_row  = (row_r == ROW_LAST);

  // a stalled pipeline keeps every stage's valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("stage valid bits moved during a stall");

  // rows of one matrix go out in order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && row_r != ROW_LAST |=> busy_r && row_r == $past(row_r) + 2'd1)
    else $error("row sequence broken");

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted request lost");

  // a new matrix never lands on rows still unsent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_res.ready |=> !$past(load))
    else $error("matrix overwritten");

endmodule
